>>> rtl/core/tcw_pkg.sv
// Shared types and codes for the text console writer.
package tcw_pkg;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_SET  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } tcw_op_t;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic       end_of_string;
    logic [4:0] target_row;
    logic [6:0] target_col;
  } tcw_req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  shown_row;
    logic [6:0]  shown_col;
    logic        scrolled;
  } tcw_rsp_t;

endpackage

>>> rtl/core/text_console_writer.sv
// Text console writer: screen store, logical cursor and display cursor register.
// Flow: a request is accepted in IDLE; its result waits in DONE and is
//   registered into the output register once that register is free.
// A put that runs off the last row adds a scroll sweep (SCROLL, then TAIL),
//   one cell per cycle through the single read and single write port.
// Reset (synchronous) starts a clearing pass over all ROWS*COLUMNS cells (2000 by
//   default); no request is taken until it ends, config writes are taken always.
module text_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 4
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  tcw_pkg::tcw_req_t in_req,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output tcw_pkg::tcw_rsp_t out_rsp,
  // attribute register
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  // Geometry derived from the parameters.
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int SW    = CW + 5;          // column sum incl. largest tab step

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] SRC_LIMIT = AW'(CELLS - COLUMNS);
  localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_MAX   = CW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,    // post-reset zero fill of the store
    ST_IDLE,     // ready for a request
    ST_SCROLL,   // moving rows up one cell per cycle
    ST_TAIL,     // last pending sweep write
    ST_DONE      // result waits for the output register
  } state_t;

  state_t state;

  // Screen store: one write port, one read port, registered read data.
  logic [15:0]   mem [CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   rd_data;

  // Cursor and configuration.
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] disp_row;
  logic [CW-1:0] disp_col;
  logic [7:0]    text_attr;

  // Sweep control (clear and scroll share the index).
  logic [AW-1:0] sweep_idx;
  logic          pend_v;
  logic [AW-1:0] pend_addr;
  logic          pend_zero;

  // Result held until the output register is free.
  logic [15:0]   res_cell;
  logic          res_scrolled;
  logic          res_read;

  logic          accept;
  logic          is_put;
  logic          is_set;
  logic          is_read;
  logic          is_newline;
  logic          is_tab;
  logic          is_char;

  logic [SW-1:0] col_sum;
  logic          col_wrap;
  logic          row_inc;
  logic [RW:0]   row_sum;
  logic          do_scroll;
  logic [RW-1:0] put_row;
  logic [CW-1:0] put_col;
  logic [AW-1:0] cur_addr;
  logic [15:0]   put_cell;

  logic          tgt_ok;
  logic [AW-1:0] tgt_addr;
  logic [RW-1:0] set_row;
  logic [CW-1:0] set_col;

  logic          src_ok;
  logic [AW-1:0] src_addr;
  logic          out_free;

  // ---------------------------------------------------------------------
  // Request decode. One request is in flight at a time; the input side is
  // open only in IDLE, independent of the output side.
  // ---------------------------------------------------------------------
  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && (state == ST_IDLE);
  assign is_put     = (in_req.op == tcw_pkg::OP_PUT);
  assign is_set     = (in_req.op == tcw_pkg::OP_SET);
  assign is_read    = (in_req.op == tcw_pkg::OP_READ);
  assign is_newline = (in_req.char_code == tcw_pkg::CH_NEWLINE);
  assign is_tab     = (in_req.char_code == tcw_pkg::CH_TAB);
  assign is_char    = !is_newline && !is_tab;

  // ---------------------------------------------------------------------
  // Cursor advance for a put. A newline forces column 0 of the next row;
  // a tab or character that lands at or past the row end wraps the same way.
  // Running off the last row pins the cursor there and triggers a scroll.
  // ---------------------------------------------------------------------
  always_comb begin
    if (is_newline) begin
      col_sum = '0;
    end else if (is_tab) begin
      col_sum = SW'(cur_col) + SW'(TAB_STEP);
    end else begin
      col_sum = SW'(cur_col) + SW'(1);
    end
  end

  assign col_wrap  = (col_sum >= SW'(COLUMNS));
  assign row_inc   = is_newline || col_wrap;
  assign put_col   = row_inc ? '0 : col_sum[CW-1:0];
  assign row_sum   = {1'b0, cur_row} + (RW+1)'(row_inc);
  assign do_scroll = (row_sum >= (RW+1)'(ROWS));
  assign put_row   = do_scroll ? ROW_MAX : row_sum[RW-1:0];

  // Linear cell address of the cursor (constant multiply).
  assign cur_addr = AW'(32'(cur_row) * 32'(COLUMNS) + 32'(cur_col));
  assign put_cell = {text_attr, in_req.char_code};

  // Target position for set-cursor and read; set saturates to the screen.
  assign tgt_ok   = (32'(in_req.target_row) < 32'(ROWS)) &&
                    (32'(in_req.target_col) < 32'(COLUMNS));
  assign tgt_addr = AW'(32'(in_req.target_row) * 32'(COLUMNS) +
                        32'(in_req.target_col));
  assign set_row  = (32'(in_req.target_row) < 32'(ROWS)) ?
                    RW'(in_req.target_row) : ROW_MAX;
  assign set_col  = (32'(in_req.target_col) < 32'(COLUMNS)) ?
                    CW'(in_req.target_col) : COL_MAX;

  // Scroll source: the cell one row below; the bottom row fills with zero.
  assign src_ok   = (sweep_idx < SRC_LIMIT);
  assign src_addr = sweep_idx + AW'(COLUMNS);

  assign out_free = !out_valid || !out_stall;

  // ---------------------------------------------------------------------
  // Store port steering. The sweep reads cell i+COLUMNS and writes its data
  // to cell i in the cycle after; writes always trail reads, so no forwarding.
  // ---------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_idx;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = tgt_addr;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept && is_put && is_char) begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr;
          mem_wdata = put_cell;
        end
        mem_re = accept && is_read && tgt_ok;
      end
      ST_SCROLL, ST_TAIL: begin
        mem_we    = pend_v;
        mem_waddr = pend_addr;
        mem_wdata = pend_zero ? '0 : rd_data;
        mem_re    = (state == ST_SCROLL) && src_ok;
        mem_raddr = src_addr;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Attribute register: written whenever enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= tcw_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      text_attr <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------
  // Control sequencer and output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      sweep_idx    <= '0;
      pend_v       <= 1'b0;
      cur_row      <= '0;
      cur_col      <= '0;
      disp_row     <= '0;
      disp_col     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // DONE reloads the output register itself when it frees up
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          sweep_idx <= sweep_idx + AW'(1);
          if (sweep_idx == LAST_CELL) begin
            sweep_idx <= '0;
            state     <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_cell     <= '0;
            res_scrolled <= 1'b0;
            res_read     <= is_read && tgt_ok;
            state        <= ST_DONE;
            if (is_put) begin
              cur_row <= put_row;
              cur_col <= put_col;
              if (in_req.end_of_string) begin
                disp_row <= put_row;
                disp_col <= put_col;
              end
              if (is_char) begin
                res_cell <= put_cell;
              end
              if (do_scroll) begin
                res_scrolled <= 1'b1;
                sweep_idx    <= '0;
                state        <= ST_SCROLL;
              end
            end else if (is_set) begin
              cur_row  <= set_row;
              cur_col  <= set_col;
              disp_row <= set_row;
              disp_col <= set_col;
            end
          end
        end
        ST_SCROLL: begin
          pend_v    <= 1'b1;
          pend_addr <= sweep_idx;
          pend_zero <= !src_ok;
          sweep_idx <= sweep_idx + AW'(1);
          if (sweep_idx == LAST_CELL) begin
            sweep_idx <= '0;
            state     <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          pend_v <= 1'b0;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_rsp.cell_value <= res_read ? rd_data : res_cell;
            out_rsp.shown_row  <= 5'(disp_row);
            out_rsp.shown_col  <= 7'(disp_col);
            out_rsp.scrolled   <= res_scrolled;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> test/tb_text_console_writer.sv
// Testbench for text_console_writer: shadow screen, random strings, handshake checks.
module tb_text_console_writer;

  // Geometry of the screen under test (matches the default RTL parameters).
  localparam int COLS         = 80;
  localparam int ROWS         = 25;
  localparam int TAB_STEP     = 4;
  // Random request budget spread over the attribute phases.
  localparam int RANDOM_ITEMS = 1375;
  localparam int ATTR_STEPS   = 7;
  // Receiver hold-off used to back the request channel up.
  localparam int HOLD_CYCLES  = 400;
  // Quiet cycles after the last result, to catch anything spurious.
  localparam int TAIL_CYCLES  = 40;
  // Worst case: ~1400 requests, plus ~130 scrolls, plus the clearing pass
  // after reset; the sum taken about four times.
  localparam int CYCLE_LIMIT  = 2_000_000;

  // Shadow copy of the console: screen store, cursors and attribute, plus
  // the queue of results owed by the block in request order.
  class screen_shadow;
    logic [15:0]       cells [ROWS*COLS];
    int unsigned       row, col;
    int unsigned       shown_r, shown_c;
    logic [7:0]        attr;
    tcw_pkg::tcw_rsp_t owed_q[$];
    int                errors;
    int                scroll_total;
    int                last_row, last_col;

    function new();
      foreach (cells[i]) cells[i] = '0;
      row = 0;
      col = 0;
      shown_r = 0;
      shown_c = 0;
      attr = tcw_pkg::ATTR_RESET;
      errors = 0;
      scroll_total = 0;
      last_row = 0;
      last_col = 0;
    endfunction

    function void set_attribute(logic [7:0] a);
      attr = a;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void take_request(tcw_pkg::tcw_req_t r);
      tcw_pkg::tcw_rsp_t want;
      want = '0;
      case (r.op)
        tcw_pkg::OP_PUT: begin
          if (r.char_code == tcw_pkg::CH_NEWLINE) begin
            col = 0;
            row++;
          end else if (r.char_code == tcw_pkg::CH_TAB) begin
            col += TAB_STEP;
          end else begin
            want.cell_value = {attr, r.char_code};
            cells[row * COLS + col] = want.cell_value;
            last_row = row;
            last_col = col;
            col++;
          end
          // tab overshoot wraps exactly like a plain row end
          if (col >= COLS) begin
            col = 0;
            row++;
          end
          if (row >= ROWS) begin
            row = ROWS - 1;
            for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) cells[i] = '0;
            want.scrolled = 1'b1;
            scroll_total++;
            if (last_row > 0) last_row--;
          end
          if (r.end_of_string) begin
            shown_r = row;
            shown_c = col;
          end
        end
        tcw_pkg::OP_SET: begin
          row = (r.target_row < ROWS) ? r.target_row : ROWS - 1;
          col = (r.target_col < COLS) ? r.target_col : COLS - 1;
          shown_r = row;
          shown_c = col;
        end
        tcw_pkg::OP_READ: begin
          if (r.target_row < ROWS && r.target_col < COLS)
            want.cell_value = cells[r.target_row * COLS + r.target_col];
        end
        default: ;
      endcase
      want.shown_row = 5'(shown_r);
      want.shown_col = 7'(shown_c);
      owed_q.push_back(want);
    endfunction

    function void note_mismatch(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endfunction

    // Compare one accepted result against the oldest owed one.
    function void match_result(tcw_pkg::tcw_rsp_t got);
      tcw_pkg::tcw_rsp_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: expected none, actual %p", $time, got);
        return;
      end
      want = owed_q.pop_front();
      if (got.cell_value !== want.cell_value)
        note_mismatch("cell_value", want.cell_value, got.cell_value);
      if (got.shown_row !== want.shown_row)
        note_mismatch("shown_row", want.shown_row, got.shown_row);
      if (got.shown_col !== want.shown_col)
        note_mismatch("shown_col", want.shown_col, got.shown_col);
      if (got.scrolled !== want.scrolled)
        note_mismatch("scrolled", want.scrolled, got.scrolled);
    endfunction
  endclass

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  tcw_pkg::tcw_req_t in_req      = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  tcw_pkg::tcw_rsp_t out_rsp;
  logic              cfg_wr_en   = 1'b0;
  logic [7:0]        cfg_wr_data = 8'h00;

  screen_shadow shadow = new();

  int  sent          = 0;     // requests accepted so far
  int  cycles        = 0;
  bit  offering      = 1'b0;  // mirrors in_valid without reading back an NBA
  bit  sender_calm   = 1'b0;  // no gaps on the request side
  bit  receiver_calm = 1'b0;  // no stalls on the result side
  bit  hold_request  = 1'b0;  // receiver: one long hold-off, then clears this

  text_console_writer uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_rsp     (out_rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int sender_pause();
    int k = $urandom_range(0, 99);
    if (sender_calm || k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  function automatic int stall_span();
    int k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(1, 2);
    if (k < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Every field random; callers then pin what matters.
  function automatic tcw_pkg::tcw_req_t random_fields();
    tcw_pkg::tcw_req_t r;
    r.op            = 2'($urandom);
    r.char_code     = 8'($urandom);
    r.end_of_string = 1'($urandom);
    r.target_row    = 5'($urandom);
    r.target_col    = 7'($urandom);
    return r;
  endfunction

  function automatic tcw_pkg::tcw_req_t make_req(tcw_pkg::tcw_op_t op, logic [7:0] ch,
                                                 logic eos, logic [4:0] trow,
                                                 logic [6:0] tcol);
    tcw_pkg::tcw_req_t r;
    r.op            = op;
    r.char_code     = ch;
    r.end_of_string = eos;
    r.target_row    = trow;
    r.target_col    = tcol;
    return r;
  endfunction

  // Offer one request, wait for the handshake, then maybe idle a while.
  // Valid stays high across back-to-back requests (no drop and re-raise).
  task automatic send_request(input tcw_pkg::tcw_req_t r);
    int pause;
    in_req   <= r;
    in_valid <= 1'b1;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.take_request(r);
    sent++;
    pause = sender_pause();
    if (pause > 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Attribute writes happen only with the block idle.
  task automatic write_attribute(input logic [7:0] a);
    drain();
    cfg_wr_data <= a;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow.set_attribute(a);
  endtask

  // One string: optional cursor placement, then puts with the last one
  // flagged as end of string; reads and stray op-3 requests mixed in.
  task automatic random_string();
    tcw_pkg::tcw_req_t r;
    int                len;
    int                k;
    bit                tame;
    // after many scrolls keep the cursor high so sweeps stay rare
    tame = shadow.scroll_total > 100;
    if (tame || $urandom_range(0, 9) < 6) begin
      r = random_fields();
      r.op = tcw_pkg::OP_SET;
      k = $urandom_range(0, 9);
      if (tame)       r.target_row = 5'($urandom_range(0, 20));
      else if (k < 8) r.target_row = 5'($urandom_range(0, ROWS - 2));
      else if (k < 9) r.target_row = 5'(ROWS - 1);
      else            r.target_row = 5'($urandom_range(ROWS, 31));
      r.target_col = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(COLS, 127))
                                                 : 7'($urandom_range(0, COLS - 1));
      send_request(r);
    end
    len = (!tame && $urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                               : $urandom_range(1, 16);
    for (int i = 0; i < len; i++) begin
      r = random_fields();
      r.op = tcw_pkg::OP_PUT;
      k = $urandom_range(0, 99);
      if (k < 3)      r.char_code = tcw_pkg::CH_NEWLINE;
      else if (k < 8) r.char_code = tcw_pkg::CH_TAB;
      r.end_of_string = (i == len - 1) || ($urandom_range(0, 19) == 0);
      send_request(r);
      k = $urandom_range(0, 99);
      if (k < 10) begin
        // read back the cell just written (tracked through scrolls)
        r = random_fields();
        r.op = tcw_pkg::OP_READ;
        r.target_row = 5'(shadow.last_row);
        r.target_col = 7'(shadow.last_col);
        send_request(r);
      end else if (k < 15) begin
        r = random_fields();
        r.op = tcw_pkg::OP_READ;
        send_request(r);
      end else if (k < 17) begin
        r = random_fields();
        r.op = tcw_pkg::OP_NONE;
        send_request(r);
      end
    end
  endtask

  // Result side: random stalls, calm stretches, and the long hold-off.
  initial begin
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (receiver_calm || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (stall_span()) @(posedge clk);
      end
    end
  end

  // Result monitor: values sampled at the edge that accepts them.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) shadow.match_result(out_rsp);
  end

  // Watchdog.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** text_console_writer: FAILED **");
    $finish;
  end

  initial begin
    int         mark;
    logic [7:0] a;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: runs with the reset attribute, so no write first.
    // cleared store
    send_request(make_req(tcw_pkg::OP_READ, 8'h00, 1'b0, 5'd0, 7'd0));
    send_request(make_req(tcw_pkg::OP_READ, 8'hFF, 1'b1, 5'd24, 7'd79));
    // display holds
    send_request(make_req(tcw_pkg::OP_PUT, 8'h41, 1'b0, 5'd31, 7'd127));
    send_request(make_req(tcw_pkg::OP_PUT, 8'hFF, 1'b1, 5'd0, 7'd0));
    send_request(make_req(tcw_pkg::OP_PUT, 8'h00, 1'b1, 5'd0, 7'd0));
    send_request(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 1'b1, 5'd0, 7'd0));
    send_request(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 1'b0, 5'd0, 7'd0));
    send_request(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 1'b1, 5'd0, 7'd0));
    send_request(make_req(tcw_pkg::OP_READ, 8'h00, 1'b0, 5'd0, 7'd0));
    send_request(make_req(tcw_pkg::OP_SET, 8'h00, 1'b0, 5'd0, 7'd78));
    // tab past row end
    send_request(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 1'b1, 5'd0, 7'd0));
    // saturates
    send_request(make_req(tcw_pkg::OP_SET, 8'hA5, 1'b1, 5'd31, 7'd127));
    // wrap + scroll
    send_request(make_req(tcw_pkg::OP_PUT, 8'h7E, 1'b1, 5'd0, 7'd0));
    send_request(make_req(tcw_pkg::OP_READ, 8'h00, 1'b0, 5'd23, 7'd79));
    // new bottom row
    send_request(make_req(tcw_pkg::OP_READ, 8'h00, 1'b0, 5'd24, 7'd79));
    // out of range
    send_request(make_req(tcw_pkg::OP_READ, 8'h5A, 1'b1, 5'd31, 7'd127));
    send_request(make_req(tcw_pkg::OP_READ, 8'h00, 1'b0, 5'd25, 7'd0));
    send_request(make_req(tcw_pkg::OP_READ, 8'h00, 1'b0, 5'd0, 7'd80));
    send_request(make_req(tcw_pkg::OP_SET, 8'h00, 1'b0, 5'd24, 7'd77));
    // tab scrolls
    send_request(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 1'b0, 5'd0, 7'd0));
    // newline scrolls
    send_request(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 1'b1, 5'd0, 7'd0));
    // unused op
    send_request(make_req(tcw_pkg::OP_NONE, 8'hC3, 1'b1, 5'd17, 7'd99));
    send_request(make_req(tcw_pkg::OP_SET, 8'h3C, 1'b1, 5'd5, 7'd10));
    // moved up twice
    send_request(make_req(tcw_pkg::OP_READ, 8'hFF, 1'b1, 5'd21, 7'd79));

    // Random phases, each under its own attribute; extremes come first.
    for (int p = 0; p < ATTR_STEPS; p++) begin
      case (p)
        0:       a = 8'h00;
        1:       a = 8'hFF;
        3:       a = 8'h80;
        5:       a = 8'h7F;
        default: a = 8'($urandom);
      endcase
      write_attribute(a);
      mark = sent + RANDOM_ITEMS / ATTR_STEPS;
      if (p == 2) begin
        // receiver holds off while requests keep coming, so input stalls
        hold_request = 1'b1;
        sender_calm  = 1'b1;
        while (sent < mark - RANDOM_ITEMS / ATTR_STEPS + 40) random_string();
        sender_calm  = 1'b0;
      end
      if (p == 4) begin
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
      end
      while (sent < mark) random_string();
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("** text_console_writer: PASSED **");
    end else begin
      $display("** text_console_writer: FAILED **");
    end
    $finish;
  end

endmodule
